@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file i2cst_check.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define I2CST_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define I2CST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/core/i2cst_pkg.sv @@
// Types, status codes and constants of the I2C slave transceiver.
package i2cst_pkg;

	localparam int BUFFER_DEPTH_DEF = 16;
	localparam int ADDR_W_MAX       = 8;
	localparam int CFG_W            = 5;

	// slave status codes, low three bits ignored
	localparam logic [7:0] SC_TX_ADDR_ACK      = 8'hA8;
	localparam logic [7:0] SC_TX_DATA_ACK      = 8'hB8;
	localparam logic [7:0] SC_TX_DATA_NACK     = 8'hC0;
	localparam logic [7:0] SC_TX_LAST_DATA     = 8'hC8;
	localparam logic [7:0] SC_RX_ADDR_ACK      = 8'h60;
	localparam logic [7:0] SC_RX_GEN_ACK       = 8'h70;
	localparam logic [7:0] SC_RX_DATA_ACK      = 8'h80;
	localparam logic [7:0] SC_RX_DATA_NACK     = 8'h88;
	localparam logic [7:0] SC_RX_GEN_DATA_ACK  = 8'h90;
	localparam logic [7:0] SC_RX_GEN_DATA_NACK = 8'h98;
	localparam logic [7:0] SC_RX_STOP          = 8'hA0;
	localparam logic [7:0] SC_BUS_FAULT        = 8'h00;

	typedef enum logic [1:0] {
		KIND_BUS   = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2,
		KIND_START = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ACT_RESUME = 2'd0,
		ACT_STOP   = 2'd1,
		ACT_NONE   = 2'd2
	} act_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] status_code;
		logic [7:0] rx_byte;
		logic [3:0] buf_index;
		logic [7:0] buf_value;
		logic       final_read;
		logic       with_data;
	} in_word_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic [1:0] bus_action;
		logic       busy_flag;
		logic       success_flag;
		logic       rx_pending_flag;
		logic       general_call_flag;
		logic [7:0] read_byte;
	} out_word_t;

	typedef struct packed {
		logic                  rd_en;
		logic [ADDR_W_MAX-1:0] rd_addr;
		logic                  wr_en;
		logic [ADDR_W_MAX-1:0] wr_addr;
		logic [7:0]            wr_data;
	} buf_req_t;

	typedef struct packed {
		act_t act;
		logic busy;
		logic ok;
		logic rxp;
		logic gc;
		logic tx_sel;
		logic rd_sel;
	} meta_t;

endpackage

@@ rtl/core/i2cst_ifs.sv @@
// Valid/ready channel interfaces for input and result words.
interface i2cst_in_if;
	logic                 valid;
	logic                 ready;
	i2cst_pkg::in_word_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface i2cst_out_if;
	logic                 valid;
	logic                 ready;
	i2cst_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/i2cst_buf.sv @@
// Shared byte buffer: one write and one registered read per cycle.
module i2cst_buf #(
	parameter int BUFFER_DEPTH = i2cst_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                clk,
	input  i2cst_pkg::buf_req_t req,
	output logic [7:0]          rdata_q
);
	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

	logic [7:0] mem [BUFFER_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr[AW-1:0]] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.rd_addr[AW-1:0]];
		end
	end

endmodule

@@ rtl/core/i2cst_ctrl.sv @@
// Event decode, pointer and flag state, size register and buffer requests.
module i2cst_ctrl #(
	parameter int BUFFER_DEPTH = i2cst_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [i2cst_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                            accept,
	input  i2cst_pkg::in_word_t             item,
	output i2cst_pkg::buf_req_t             req,
	output i2cst_pkg::meta_t                meta
);
	localparam int PTR_W = $clog2(BUFFER_DEPTH + 1);
	localparam int AW    = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int AWM   = i2cst_pkg::ADDR_W_MAX;
	localparam int CMP_W = (PTR_W > i2cst_pkg::CFG_W) ? PTR_W : i2cst_pkg::CFG_W;
	localparam int IDX_W = (PTR_W > 4) ? PTR_W : 4;
	localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(BUFFER_DEPTH);
	localparam logic [IDX_W-1:0] DEPTH_I = IDX_W'(BUFFER_DEPTH);

	logic [i2cst_pkg::CFG_W-1:0] tx_size_q;
	logic [PTR_W-1:0]            ptr_q, ptr_d, p_sel;
	logic                        busy_q, busy_d;
	logic                        ok_q, ok_d;
	logic                        rxp_q, rxp_d;
	logic                        gc_q, gc_d;
	logic                        on_q, on_d;
	logic [7:0]                  code;
	logic                        ptr_lt, p_lt, idx_lt;
	logic                        rd_hit, wr_hit;

	assign code   = {item.status_code[7:3], 3'b000};
	assign ptr_lt = ptr_q < DEPTH_P;
	assign idx_lt = IDX_W'(item.buf_index) < DEPTH_I;
	assign p_sel  = (code == i2cst_pkg::SC_TX_ADDR_ACK) ? '0 : ptr_q;
	assign p_lt   = p_sel < DEPTH_P;

	always_comb begin
		ptr_d       = ptr_q;
		busy_d      = busy_q;
		ok_d        = ok_q;
		rxp_d       = rxp_q;
		gc_d        = gc_q;
		on_d        = on_q;
		rd_hit      = 1'b0;
		wr_hit      = 1'b0;
		req.rd_addr = '0;
		req.wr_addr = '0;
		req.wr_data = item.buf_value;
		meta.act    = i2cst_pkg::ACT_NONE;
		meta.tx_sel = 1'b0;
		meta.rd_sel = 1'b0;
		case (i2cst_pkg::kind_t'(item.kind))
			i2cst_pkg::KIND_BUS: begin
				if (on_q) begin
					meta.act = i2cst_pkg::ACT_RESUME;
					case (code)
						i2cst_pkg::SC_TX_ADDR_ACK, i2cst_pkg::SC_TX_DATA_ACK: begin
							rd_hit      = p_lt;
							meta.tx_sel = p_lt;
							req.rd_addr = AWM'(p_sel[AW-1:0]);
							ptr_d       = p_lt ? p_sel + PTR_W'(1) : p_sel;
							busy_d      = 1'b1;
						end
						i2cst_pkg::SC_TX_DATA_NACK: begin
							if (CMP_W'(ptr_q) == CMP_W'(tx_size_q)) begin
								ok_d = 1'b1;
							end
							busy_d = 1'b0;
						end
						i2cst_pkg::SC_RX_GEN_ACK, i2cst_pkg::SC_RX_ADDR_ACK: begin
							if (code == i2cst_pkg::SC_RX_GEN_ACK) begin
								gc_d = 1'b1;
							end
							rxp_d  = 1'b1;
							ptr_d  = '0;
							busy_d = 1'b1;
						end
						i2cst_pkg::SC_RX_GEN_DATA_ACK, i2cst_pkg::SC_RX_DATA_ACK: begin
							wr_hit      = ptr_lt;
							req.wr_addr = AWM'(ptr_q[AW-1:0]);
							req.wr_data = item.rx_byte;
							ptr_d       = ptr_lt ? ptr_q + PTR_W'(1) : ptr_q;
							ok_d        = 1'b1;
							busy_d      = 1'b1;
						end
						i2cst_pkg::SC_RX_STOP: begin
							busy_d = 1'b0;
						end
						i2cst_pkg::SC_RX_DATA_NACK, i2cst_pkg::SC_RX_GEN_DATA_NACK,
						i2cst_pkg::SC_TX_LAST_DATA, i2cst_pkg::SC_BUS_FAULT: begin
							meta.act = i2cst_pkg::ACT_STOP;
							on_d     = 1'b0;
						end
						default: begin
						end
					endcase
				end
			end
			i2cst_pkg::KIND_WRITE: begin
				wr_hit      = idx_lt;
				req.wr_addr = AWM'(item.buf_index);
			end
			i2cst_pkg::KIND_READ: begin
				if (ok_q) begin
					rd_hit      = idx_lt;
					meta.rd_sel = idx_lt;
					req.rd_addr = AWM'(item.buf_index);
					if (item.final_read) begin
						rxp_d = 1'b0;
					end
				end
			end
			i2cst_pkg::KIND_START: begin
				ok_d     = 1'b0;
				rxp_d    = 1'b0;
				gc_d     = 1'b0;
				on_d     = 1'b1;
				busy_d   = item.with_data;
				meta.act = i2cst_pkg::ACT_RESUME;
			end
			default: begin
			end
		endcase
		req.rd_en = rd_hit & accept;
		req.wr_en = wr_hit & accept;
		meta.busy = busy_d;
		meta.ok   = ok_d;
		meta.rxp  = rxp_d;
		meta.gc   = gc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_size_q <= '0;
		end else if (cfg_we) begin
			tx_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			busy_q <= 1'b0;
			ok_q   <= 1'b0;
			rxp_q  <= 1'b0;
			gc_q   <= 1'b0;
			on_q   <= 1'b1;
		end else if (accept) begin
			ptr_q  <= ptr_d;
			busy_q <= busy_d;
			ok_q   <= ok_d;
			rxp_q  <= rxp_d;
			gc_q   <= gc_d;
			on_q   <= on_d;
		end
	end

endmodule

@@ rtl/core/i2cst_resp.sv @@
// Result stage and output register with valid/ready flow control.
module i2cst_resp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  i2cst_pkg::meta_t     meta,
	input  logic [7:0]           rdata,
	output logic                 ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output i2cst_pkg::out_word_t out_data
);
	logic                 valid_s1;
	i2cst_pkg::meta_t     meta_s1;
	logic                 valid_s2;
	i2cst_pkg::out_word_t data_s2;
	logic                 s2_free;
	logic                 adv_s1;

	assign s2_free   = !valid_s2 || out_ready;
	assign adv_s1    = valid_s1 && s2_free;
	assign ready     = !valid_s1 || s2_free;
	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta;
		end
		if (adv_s1) begin
			data_s2.tx_byte           <= meta_s1.tx_sel ? rdata : 8'd0;
			data_s2.bus_action        <= meta_s1.act;
			data_s2.busy_flag         <= meta_s1.busy;
			data_s2.success_flag      <= meta_s1.ok;
			data_s2.rx_pending_flag   <= meta_s1.rxp;
			data_s2.general_call_flag <= meta_s1.gc;
			data_s2.read_byte         <= meta_s1.rd_sel ? rdata : 8'd0;
		end
	end

endmodule

@@ rtl/core/i2c_slave_transceiver.sv @@
// I2C slave transceiver event handler: top level.
// State update and buffer access happen in the cycle a word is accepted; its result
// passes stage 1, then the output register; one word per cycle unless output stalls.
// The buffer memory has one write and one read port, used at most once per word.
// Reset clears pointer, flags and size register and enables the interface.
// Buffer contents are undefined until written.
module i2c_slave_transceiver #(
	parameter int BUFFER_DEPTH = i2cst_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [i2cst_pkg::CFG_W-1:0] cfg_wdata,
	i2cst_in_if.sink                    item,
	i2cst_out_if.source                 result
);
	logic                accept;
	logic                ready;
	i2cst_pkg::buf_req_t req;
	i2cst_pkg::meta_t    meta;
	logic [7:0]          rdata;

	assign item.ready = ready;
	assign accept     = item.valid && ready;

	i2cst_ctrl #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.item      (item.data),
		.req       (req),
		.meta      (meta)
	);

	i2cst_buf #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_buf (
		.clk     (clk),
		.req     (req),
		.rdata_q (rdata)
	);

	i2cst_resp u_resp (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.meta      (meta),
		.rdata     (rdata),
		.ready     (ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (result.data)
	);

endmodule

@@ rtl/core/i2cst_check.sv @@
// Port-level checker for the transceiver result channel, with its bind.
`include "assert_macros.svh"

module i2cst_check (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input i2cst_pkg::out_word_t out_data
);

	`I2CST_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`I2CST_ASSERT(a_read_needs_ok, clk, arst_n, out_valid && out_data.read_byte != 8'd0 |-> out_data.success_flag)
	`I2CST_ASSERT(a_tx_busy, clk, arst_n, out_valid && out_data.tx_byte != 8'd0 |-> out_data.busy_flag && out_data.bus_action == i2cst_pkg::ACT_RESUME)
	`I2CST_ASSERT(a_stop_quiet, clk, arst_n, out_valid && out_data.bus_action == i2cst_pkg::ACT_STOP |-> out_data.tx_byte == 8'd0 && out_data.read_byte == 8'd0)

endmodule

bind i2c_slave_transceiver i2cst_check u_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the I2C slave transceiver: scoreboard class plus driving tasks.
module tb;

	localparam int BUF_DEPTH   = i2cst_pkg::BUFFER_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 200000;

	class handler_scoreboard;
		logic [7:0]           store_bytes [BUF_DEPTH];
		bit                   entry_written [BUF_DEPTH];
		logic [4:0]           byte_ptr;
		logic [4:0]           msg_size;
		bit                   busy, xfer_ok, rx_pend, gen_call, iface_on;
		i2cst_pkg::out_word_t expected_words [$];
		int                   errors;

		function new();
			byte_ptr = '0;
			msg_size = '0;
			busy = 0;
			xfer_ok = 0;
			rx_pend = 0;
			gen_call = 0;
			iface_on = 1;
			errors = 0;
			foreach (entry_written[i])
				entry_written[i] = 0;
		endfunction

		function void note_word(i2cst_pkg::in_word_t w);
			i2cst_pkg::out_word_t e;
			logic [7:0]           code;
			e = '0;
			e.bus_action = i2cst_pkg::ACT_NONE;
			code = w.status_code & 8'hF8;
			case (w.kind)
				i2cst_pkg::KIND_BUS: begin
					if (iface_on) begin
						e.bus_action = i2cst_pkg::ACT_RESUME;
						case (code)
							i2cst_pkg::SC_TX_ADDR_ACK, i2cst_pkg::SC_TX_DATA_ACK: begin
								if (code == i2cst_pkg::SC_TX_ADDR_ACK)
									byte_ptr = '0;
								if (byte_ptr < BUF_DEPTH)
									e.tx_byte = store_bytes[byte_ptr[3:0]];
								if (byte_ptr < BUF_DEPTH)
									byte_ptr = byte_ptr + 5'd1;
								busy = 1;
							end
							i2cst_pkg::SC_TX_DATA_NACK: begin
								if (byte_ptr == msg_size)
									xfer_ok = 1;
								busy = 0;
							end
							i2cst_pkg::SC_RX_GEN_ACK, i2cst_pkg::SC_RX_ADDR_ACK: begin
								if (code == i2cst_pkg::SC_RX_GEN_ACK)
									gen_call = 1;
								rx_pend = 1;
								byte_ptr = '0;
								busy = 1;
							end
							i2cst_pkg::SC_RX_GEN_DATA_ACK, i2cst_pkg::SC_RX_DATA_ACK: begin
								if (byte_ptr < BUF_DEPTH) begin
									store_bytes[byte_ptr[3:0]] = w.rx_byte;
									entry_written[byte_ptr[3:0]] = 1;
									byte_ptr = byte_ptr + 5'd1;
								end
								xfer_ok = 1;
								busy = 1;
							end
							i2cst_pkg::SC_RX_STOP: busy = 0;
							i2cst_pkg::SC_RX_DATA_NACK, i2cst_pkg::SC_RX_GEN_DATA_NACK,
							i2cst_pkg::SC_TX_LAST_DATA, i2cst_pkg::SC_BUS_FAULT: begin
								e.bus_action = i2cst_pkg::ACT_STOP;
								iface_on = 0;
							end
							default: ;
						endcase
					end
				end
				i2cst_pkg::KIND_WRITE: begin
					store_bytes[w.buf_index] = w.buf_value;
					entry_written[w.buf_index] = 1;
				end
				i2cst_pkg::KIND_READ: begin
					if (xfer_ok) begin
						e.read_byte = store_bytes[w.buf_index];
						if (w.final_read)
							rx_pend = 0;
					end
				end
				default: begin
					xfer_ok = 0;
					rx_pend = 0;
					gen_call = 0;
					iface_on = 1;
					busy = w.with_data;
					e.bus_action = i2cst_pkg::ACT_RESUME;
				end
			endcase
			e.busy_flag = busy;
			e.success_flag = xfer_ok;
			e.rx_pending_flag = rx_pend;
			e.general_call_flag = gen_call;
			expected_words.push_back(e);
		endfunction

		function void field_check(string name, logic [7:0] exp_val, logic [7:0] got);
			if (got !== exp_val) begin
				$error("%s: expected %0h, got %0h", name, exp_val, got);
				errors++;
			end
		endfunction

		function void check_word(i2cst_pkg::out_word_t r);
			i2cst_pkg::out_word_t e;
			if (expected_words.size() == 0) begin
				$error("result word with none expected");
				errors++;
				return;
			end
			e = expected_words.pop_front();
			field_check("tx_byte", e.tx_byte, r.tx_byte);
			field_check("bus_action", 8'(e.bus_action), 8'(r.bus_action));
			field_check("busy_flag", 8'(e.busy_flag), 8'(r.busy_flag));
			field_check("success_flag", 8'(e.success_flag), 8'(r.success_flag));
			field_check("rx_pending_flag", 8'(e.rx_pending_flag),
				8'(r.rx_pending_flag));
			field_check("general_call_flag", 8'(e.general_call_flag),
				8'(r.general_call_flag));
			field_check("read_byte", e.read_byte, r.read_byte);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [4:0]  cfg_wdata;
	int unsigned src_idle_pct;
	int unsigned stall_pct;
	int unsigned counted;
	int unsigned cycle_count;
	logic [7:0]  event_codes [12] = '{
		i2cst_pkg::SC_TX_ADDR_ACK, i2cst_pkg::SC_TX_DATA_ACK, i2cst_pkg::SC_TX_DATA_NACK,
		i2cst_pkg::SC_TX_LAST_DATA, i2cst_pkg::SC_RX_ADDR_ACK, i2cst_pkg::SC_RX_GEN_ACK,
		i2cst_pkg::SC_RX_DATA_ACK, i2cst_pkg::SC_RX_DATA_NACK,
		i2cst_pkg::SC_RX_GEN_DATA_ACK, i2cst_pkg::SC_RX_GEN_DATA_NACK,
		i2cst_pkg::SC_RX_STOP, i2cst_pkg::SC_BUS_FAULT};

	handler_scoreboard sb = new();

	i2cst_in_if  in_ch ();
	i2cst_out_if out_ch ();

	i2c_slave_transceiver u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (in_ch.sink),
		.result    (out_ch.source)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// input noted before result checked, so both sides see one order
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready)
			sb.note_word(in_ch.data);
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_word(out_ch.data);
	end

	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic i2cst_pkg::in_word_t bus_word(logic [7:0] code, logic [7:0] rx);
		i2cst_pkg::in_word_t w;
		w = $urandom;
		w.kind = i2cst_pkg::KIND_BUS;
		w.status_code = code | {5'd0, w.status_code[2:0]};
		w.rx_byte = rx;
		return w;
	endfunction

	function automatic i2cst_pkg::in_word_t write_word(logic [3:0] idx, logic [7:0] val);
		i2cst_pkg::in_word_t w;
		w = $urandom;
		w.kind = i2cst_pkg::KIND_WRITE;
		w.buf_index = idx;
		w.buf_value = val;
		return w;
	endfunction

	function automatic i2cst_pkg::in_word_t read_word(logic [3:0] idx, logic fin);
		i2cst_pkg::in_word_t w;
		w = $urandom;
		w.kind = i2cst_pkg::KIND_READ;
		w.buf_index = idx;
		w.final_read = fin;
		return w;
	endfunction

	function automatic i2cst_pkg::in_word_t start_word(logic wd);
		i2cst_pkg::in_word_t w;
		w = $urandom;
		w.kind = i2cst_pkg::KIND_START;
		w.with_data = wd;
		return w;
	endfunction

	// entered and left at a falling edge; valid stays high into the next word
	task automatic push_word(i2cst_pkg::in_word_t w);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= w;
		do
			@(posedge clk);
		while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic fill_entry(logic [3:0] idx);
		if (!sb.entry_written[idx])
			push_word(write_word(idx, 8'($urandom)));
	endtask

	// buffer entries are written before any word can read them
	task automatic issue(i2cst_pkg::in_word_t w);
		logic [7:0] code;
		code = w.status_code & 8'hF8;
		if (w.kind == i2cst_pkg::KIND_READ)
			fill_entry(w.buf_index);
		if (w.kind == i2cst_pkg::KIND_BUS && code == i2cst_pkg::SC_TX_ADDR_ACK)
			fill_entry(4'd0);
		if (w.kind == i2cst_pkg::KIND_BUS && code == i2cst_pkg::SC_TX_DATA_ACK &&
			sb.byte_ptr < BUF_DEPTH)
			fill_entry(sb.byte_ptr[3:0]);
		if (!(w.kind == i2cst_pkg::KIND_BUS && !sb.iface_on))
			counted++;
		push_word(w);
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (sb.expected_words.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_msg_size(logic [4:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.msg_size = v;
	endtask

	task automatic run_random(int unsigned target);
		int unsigned first;
		int unsigned pick;
		int          n;
		int          k;
		bit          gc;
		first = counted;
		while (counted - first < target) begin
			pick = $urandom_range(99);
			if (pick < 25) begin
				// master write: address, data run, end, then host pulls the bytes
				if (!sb.iface_on || $urandom_range(2) == 0)
					issue(start_word(1'($urandom_range(1))));
				gc = 1'($urandom_range(1));
				issue(bus_word(gc ? i2cst_pkg::SC_RX_GEN_ACK : i2cst_pkg::SC_RX_ADDR_ACK,
					8'($urandom)));
				n = ($urandom_range(7) == 0) ? $urandom_range(20, 14) : $urandom_range(6);
				repeat (n)
					issue(bus_word((gc && $urandom_range(3) != 0) ?
						i2cst_pkg::SC_RX_GEN_DATA_ACK : i2cst_pkg::SC_RX_DATA_ACK,
						8'($urandom)));
				k = $urandom_range(9);
				if (k < 7)
					issue(bus_word(i2cst_pkg::SC_RX_STOP, 8'($urandom)));
				else if (k < 8)
					issue(bus_word(i2cst_pkg::SC_RX_DATA_NACK, 8'($urandom)));
				else if (k < 9)
					issue(bus_word(i2cst_pkg::SC_RX_GEN_DATA_NACK, 8'($urandom)));
				else
					issue(bus_word(i2cst_pkg::SC_BUS_FAULT, 8'($urandom)));
				k = $urandom_range(4, 1);
				for (int i = 0; i < k; i++)
					issue(read_word(4'($urandom_range(15)), i == k - 1));
			end else if (pick < 50) begin
				// master read: lengths cluster round the message size
				repeat ($urandom_range(3))
					issue(write_word(4'($urandom_range(15)), 8'($urandom)));
				if (!sb.iface_on || $urandom_range(2) == 0)
					issue(start_word($urandom_range(3) != 0));
				if ($urandom_range(7) == 0)
					n = $urandom_range(20, 15);
				else
					n = int'(sb.msg_size) - 2 + int'($urandom_range(2));
				if (n < 0)
					n = 0;
				issue(bus_word(i2cst_pkg::SC_TX_ADDR_ACK, 8'($urandom)));
				repeat (n)
					issue(bus_word(i2cst_pkg::SC_TX_DATA_ACK, 8'($urandom)));
				if ($urandom_range(9) < 7)
					issue(bus_word(i2cst_pkg::SC_TX_DATA_NACK, 8'($urandom)));
				else
					issue(bus_word(i2cst_pkg::SC_TX_LAST_DATA, 8'($urandom)));
				if ($urandom_range(1))
					issue(read_word(4'($urandom_range(15)), 1'($urandom_range(1))));
			end else if (pick < 65) begin
				if ($urandom_range(1))
					issue(write_word(4'($urandom_range(15)), 8'($urandom)));
				else
					issue(read_word(4'($urandom_range(15)), 1'($urandom_range(1))));
			end else if (pick < 72) begin
				issue(start_word(1'($urandom_range(1))));
			end else if (pick < 86) begin
				issue(bus_word(event_codes[4'($urandom_range(11))], 8'($urandom)));
			end else begin
				issue(i2cst_pkg::in_word_t'($urandom));
			end
			if ($urandom_range(39) == 0)
				drain_results();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		src_idle_pct = 0;
		stall_pct = 0;
		counted = 0;
		cycle_count = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_msg_size(5'd0);

		// directed words
		issue(write_word(4'd0, 8'h00));
		issue(write_word(4'd15, 8'hFF));
		issue(write_word(4'd1, 8'hA5));
		issue(read_word(4'd0, 1'b1));
		issue(bus_word(i2cst_pkg::SC_RX_GEN_ACK, 8'h3C));
		issue(bus_word(i2cst_pkg::SC_RX_GEN_DATA_ACK, 8'hFF));
		issue(bus_word(i2cst_pkg::SC_RX_DATA_ACK, 8'h00));
		issue(bus_word(i2cst_pkg::SC_RX_STOP, 8'h11));
		issue(read_word(4'd0, 1'b0));
		issue(read_word(4'd1, 1'b1));
		issue(bus_word(8'hF8, 8'h5A));
		issue(start_word(1'b1));
		issue(bus_word(i2cst_pkg::SC_TX_ADDR_ACK, 8'h00));
		issue(bus_word(i2cst_pkg::SC_TX_DATA_ACK, 8'hFF));
		issue(bus_word(i2cst_pkg::SC_TX_DATA_NACK, 8'h00));
		issue(bus_word(i2cst_pkg::SC_RX_ADDR_ACK, 8'h00));
		issue(bus_word(i2cst_pkg::SC_RX_DATA_NACK, 8'hFF));
		issue(bus_word(i2cst_pkg::SC_TX_ADDR_ACK, 8'h00));
		issue(start_word(1'b0));
		issue(bus_word(i2cst_pkg::SC_RX_ADDR_ACK, 8'h00));
		issue(bus_word(i2cst_pkg::SC_RX_GEN_DATA_NACK, 8'h00));
		issue(start_word(1'b0));
		issue(bus_word(i2cst_pkg::SC_TX_LAST_DATA, 8'h00));
		issue(start_word(1'b1));
		issue(bus_word(i2cst_pkg::SC_BUS_FAULT, 8'hFF));
		issue(start_word(1'b0));

		// random phases with varied source idling and result stalls, each with its own message size
		drain_results();
		set_msg_size(5'd16);
		run_random(200);

		drain_results();
		src_idle_pct = 66;
		stall_pct = 0;
		set_msg_size(5'd0);
		run_random(200);

		drain_results();
		src_idle_pct = 0;
		stall_pct = 66;
		set_msg_size(5'($urandom_range(16)));
		run_random(200);

		drain_results();
		src_idle_pct = 28;
		stall_pct = 28;
		set_msg_size(5'($urandom_range(16)));
		run_random(200);

		drain_results();
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/i2cst_pkg.sv
rtl/core/i2cst_ifs.sv
rtl/core/i2cst_buf.sv
rtl/core/i2cst_ctrl.sv
rtl/core/i2cst_resp.sv
rtl/core/i2c_slave_transceiver.sv
rtl/core/i2cst_check.sv
verif/tb.sv
